### hdl/c2d_pkg.sv
// ----------------------------------------------------------------------------
// c2d_pkg
// Shared constants, codes and types of the 5x5 multi-filter convolution.
// ----------------------------------------------------------------------------
package c2d_pkg;

   localparam int IN_SIZE  = 32;
   localparam int KERNEL   = 5;
   localparam int FILTERS  = 6;
   localparam int OUT_SIZE = IN_SIZE - KERNEL + 1;
   localparam int KK       = KERNEL * KERNEL;

   localparam int IMG_DEPTH = IN_SIZE * IN_SIZE;
   localparam int WGT_DEPTH = FILTERS * KK;
   localparam int IMG_AW    = $clog2(IMG_DEPTH);
   localparam int WGT_AW    = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
   localparam int BIAS_AW   = (FILTERS > 1) ? $clog2(FILTERS) : 1;
   localparam int KC_W      = (KERNEL > 1) ? $clog2(KERNEL) : 1;

   // jump from the end of one kernel row to the start of the next
   localparam int ROW_STEP = IN_SIZE - KERNEL + 1;

   localparam int KIND_W     = 2;
   localparam int FILT_W     = 3;
   localparam int POS_W      = 5;
   localparam int VAL_W      = 16;
   localparam int PROD_W     = 2 * VAL_W;
   localparam int SUM_W      = 40;
   localparam int FRAC_SHIFT = 8;

   typedef enum logic [KIND_W-1:0] {
      KIND_PIXEL   = 2'd0,
      KIND_WEIGHT  = 2'd1,
      KIND_BIAS    = 2'd2,
      KIND_COMPUTE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN
   } state_type;

   typedef enum logic {
      STATUS_OK    = 1'b0,
      STATUS_RANGE = 1'b1
   } status_type;

   typedef struct packed {
      logic vld;
      logic first;
      logic last;
   } tap_type;

endpackage

### hdl/c2d_ram.sv
// ----------------------------------------------------------------------------
// c2d_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module c2d_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/c2d_agen.sv
// ----------------------------------------------------------------------------
// c2d_agen
// Tap sequencer: walks the kernel window and drives image and weight
// read addresses, one tap per cycle while run is high.
// ----------------------------------------------------------------------------
module c2d_agen (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  logic                        run,
   input  logic [c2d_pkg::IMG_AW-1:0]  img_base,
   input  logic [c2d_pkg::WGT_AW-1:0]  wgt_base,
   output logic [c2d_pkg::IMG_AW-1:0]  img_addr,
   output logic [c2d_pkg::WGT_AW-1:0]  wgt_addr,
   output c2d_pkg::tap_type            tap
);

   logic [c2d_pkg::KC_W-1:0]   kw_ff, kw_in;
   logic [c2d_pkg::KC_W-1:0]   kh_ff, kh_in;
   logic [c2d_pkg::IMG_AW-1:0] img_addr_ff, img_addr_in;
   logic [c2d_pkg::WGT_AW-1:0] wgt_addr_ff, wgt_addr_in;
   logic                       row_end;

   assign row_end = (kw_ff == c2d_pkg::KC_W'(c2d_pkg::KERNEL - 1));

   always_comb begin
      kw_in       = kw_ff;
      kh_in       = kh_ff;
      img_addr_in = img_addr_ff;
      wgt_addr_in = wgt_addr_ff;
      if (load) begin
         kw_in       = '0;
         kh_in       = '0;
         img_addr_in = img_base;
         wgt_addr_in = wgt_base;
      end else if (run) begin
         wgt_addr_in = wgt_addr_ff + c2d_pkg::WGT_AW'(1);
         if (row_end) begin
            kw_in       = '0;
            kh_in       = kh_ff + c2d_pkg::KC_W'(1);
            img_addr_in = img_addr_ff + c2d_pkg::IMG_AW'(c2d_pkg::ROW_STEP);
         end else begin
            kw_in       = kw_ff + c2d_pkg::KC_W'(1);
            img_addr_in = img_addr_ff + c2d_pkg::IMG_AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kw_ff <= '0;
         kh_ff <= '0;
      end else begin
         kw_ff <= kw_in;
         kh_ff <= kh_in;
      end
      img_addr_ff <= img_addr_in;
      wgt_addr_ff <= wgt_addr_in;
   end

   assign img_addr  = img_addr_ff;
   assign wgt_addr  = wgt_addr_ff;
   assign tap.vld   = run;
   assign tap.first = (kw_ff == '0) && (kh_ff == '0);
   assign tap.last  = row_end && (kh_ff == c2d_pkg::KC_W'(c2d_pkg::KERNEL - 1));

endmodule

### hdl/c2d_mac.sv
// ----------------------------------------------------------------------------
// c2d_mac
// Shared multiply-accumulate: registered product, then a 40-bit accumulator
// seeded with the scaled bias on the first tap.
// ----------------------------------------------------------------------------
module c2d_mac (
   input  logic                       clock,
   input  logic                       reset,
   input  c2d_pkg::tap_type           tap,
   input  logic [c2d_pkg::VAL_W-1:0]  pixel,
   input  logic [c2d_pkg::VAL_W-1:0]  weight,
   input  logic [c2d_pkg::VAL_W-1:0]  bias,
   output logic                       done,
   output logic [c2d_pkg::SUM_W-1:0]  sum
);

   c2d_pkg::tap_type                   rd_tap_ff;
   c2d_pkg::tap_type                   prod_tap_ff;
   logic signed [c2d_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic signed [c2d_pkg::SUM_W-1:0]   acc_ff, acc_in;
   logic signed [c2d_pkg::SUM_W-1:0]   bias_scaled;
   logic signed [c2d_pkg::SUM_W-1:0]   prod_ext;

   assign prod_in = $signed(pixel) * $signed(weight);

   // bias is q8.8, sum is q24.16
   assign bias_scaled = $signed({{(c2d_pkg::SUM_W - c2d_pkg::VAL_W){bias[c2d_pkg::VAL_W-1]}},
                                 bias}) <<< c2d_pkg::FRAC_SHIFT;
   assign prod_ext    = $signed({{(c2d_pkg::SUM_W - c2d_pkg::PROD_W){prod_ff[c2d_pkg::PROD_W-1]}},
                                 prod_ff});

   assign acc_in = (prod_tap_ff.first ? bias_scaled : acc_ff) + prod_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_tap_ff   <= '0;
         prod_tap_ff <= '0;
      end else begin
         rd_tap_ff   <= tap;
         prod_tap_ff <= rd_tap_ff;
      end
      prod_ff <= prod_in;
      if (prod_tap_ff.vld) begin
         acc_ff <= acc_in;
      end
   end

   assign done = prod_tap_ff.vld && prod_tap_ff.last;
   assign sum  = acc_in;

endmodule

### hdl/conv2d_5x5_multi_filter.sv
// ----------------------------------------------------------------------------
// conv2d_5x5_multi_filter
// Valid 5x5 convolution over a stored 32x32 image with six filters and biases.
// ----------------------------------------------------------------------------
// Load beats (pixel, weight, bias) may follow each other every cycle while
// busy is low; an out-of-range load is dropped without a response. A compute
// beat that names a filter or output position out of range is answered with
// status 1 and sum 0 in the cycle after it is taken. A valid compute beat
// holds busy until its result strobes, in the cycle busy drops, and no new
// beat is taken meanwhile: the single shared multiplier does one kernel tap
// per cycle over the 25 taps of the window, out of the image and weight RAMs,
// through the RAM read and product register stages. The response strobe lasts
// exactly one cycle and cannot be held off, so capture it when it is high.
module conv2d_5x5_multi_filter (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [c2d_pkg::KIND_W-1:0]  req_kind,
   input  logic [c2d_pkg::FILT_W-1:0]  req_filter_index,
   input  logic [c2d_pkg::POS_W-1:0]   req_row,
   input  logic [c2d_pkg::POS_W-1:0]   req_col,
   input  logic signed [c2d_pkg::VAL_W-1:0] req_value,
   output logic                        rsp_strobe,
   output logic signed [c2d_pkg::SUM_W-1:0] rsp_sum,
   output logic                        rsp_status
);

   c2d_pkg::state_type         state_ff, state_in;
   logic                       accept;
   logic                       pix_ok, wgt_ok, bias_ok, query_ok;
   logic                       is_pixel, is_weight, is_bias, is_compute;
   logic                       load_query, run;
   logic [c2d_pkg::IMG_AW-1:0] img_req_addr, img_rd_addr;
   logic [c2d_pkg::WGT_AW-1:0] wgt_req_addr, wgt_base, wgt_rd_addr;
   logic [c2d_pkg::BIAS_AW-1:0] bias_addr;
   logic [c2d_pkg::VAL_W-1:0]  pixel_q, weight_q, bias_q;
   c2d_pkg::tap_type           tap;
   logic                       mac_done;
   logic [c2d_pkg::SUM_W-1:0]  mac_sum;
   logic                       rsp_strobe_ff, rsp_strobe_in;
   logic [c2d_pkg::SUM_W-1:0]  rsp_sum_ff, rsp_sum_in;
   logic                       rsp_status_ff, rsp_status_in;

   assign accept     = start && !busy;
   assign is_pixel   = (req_kind == c2d_pkg::KIND_PIXEL);
   assign is_weight  = (req_kind == c2d_pkg::KIND_WEIGHT);
   assign is_bias    = (req_kind == c2d_pkg::KIND_BIAS);
   assign is_compute = (req_kind == c2d_pkg::KIND_COMPUTE);

   assign pix_ok   = (int'(req_row) < c2d_pkg::IN_SIZE) && (int'(req_col) < c2d_pkg::IN_SIZE);
   assign bias_ok  = (int'(req_filter_index) < c2d_pkg::FILTERS);
   assign wgt_ok   = bias_ok && (int'(req_row) < c2d_pkg::KERNEL)
                     && (int'(req_col) < c2d_pkg::KERNEL);
   assign query_ok = bias_ok && (int'(req_row) < c2d_pkg::OUT_SIZE)
                     && (int'(req_col) < c2d_pkg::OUT_SIZE);

   assign img_req_addr = c2d_pkg::IMG_AW'(req_row) * c2d_pkg::IMG_AW'(c2d_pkg::IN_SIZE)
                         + c2d_pkg::IMG_AW'(req_col);
   assign wgt_base     = c2d_pkg::WGT_AW'(req_filter_index) * c2d_pkg::WGT_AW'(c2d_pkg::KK);
   assign wgt_req_addr = wgt_base
                         + c2d_pkg::WGT_AW'(req_row) * c2d_pkg::WGT_AW'(c2d_pkg::KERNEL)
                         + c2d_pkg::WGT_AW'(req_col);
   assign bias_addr    = c2d_pkg::BIAS_AW'(req_filter_index);

   // sequencer
   always_comb begin
      state_in   = state_ff;
      load_query = 1'b0;
      run        = 1'b0;
      busy       = 1'b1;
      case (state_ff)
         c2d_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (accept && is_compute && query_ok) begin
               load_query = 1'b1;
               state_in   = c2d_pkg::ST_ISSUE;
            end
         end
         c2d_pkg::ST_ISSUE: begin
            run = 1'b1;
            if (tap.last) begin
               state_in = c2d_pkg::ST_DRAIN;
            end
         end
         c2d_pkg::ST_DRAIN: begin
            if (mac_done) begin
               state_in = c2d_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = c2d_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= c2d_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   c2d_agen u_agen (
      .clock    (clock),
      .reset    (reset),
      .load     (load_query),
      .run      (run),
      .img_base (img_req_addr),
      .wgt_base (wgt_base),
      .img_addr (img_rd_addr),
      .wgt_addr (wgt_rd_addr),
      .tap      (tap)
   );

   c2d_ram #(
      .WIDTH (c2d_pkg::VAL_W),
      .DEPTH (c2d_pkg::IMG_DEPTH)
   ) u_image_ram (
      .clock   (clock),
      .wr_en   (accept && is_pixel && pix_ok),
      .wr_addr (img_req_addr),
      .wr_data (req_value),
      .rd_en   (run),
      .rd_addr (img_rd_addr),
      .rd_data (pixel_q)
   );

   c2d_ram #(
      .WIDTH (c2d_pkg::VAL_W),
      .DEPTH (c2d_pkg::WGT_DEPTH)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (accept && is_weight && wgt_ok),
      .wr_addr (wgt_req_addr),
      .wr_data (req_value),
      .rd_en   (run),
      .rd_addr (wgt_rd_addr),
      .rd_data (weight_q)
   );

   // bias is read once per query and held on the ram output until the next one
   c2d_ram #(
      .WIDTH (c2d_pkg::VAL_W),
      .DEPTH (c2d_pkg::FILTERS)
   ) u_bias_ram (
      .clock   (clock),
      .wr_en   (accept && is_bias && bias_ok),
      .wr_addr (bias_addr),
      .wr_data (req_value),
      .rd_en   (load_query),
      .rd_addr (bias_addr),
      .rd_data (bias_q)
   );

   c2d_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .tap    (tap),
      .pixel  (pixel_q),
      .weight (weight_q),
      .bias   (bias_q),
      .done   (mac_done),
      .sum    (mac_sum)
   );

   always_comb begin
      rsp_strobe_in = mac_done || (accept && is_compute && !query_ok);
      rsp_sum_in    = mac_done ? mac_sum : '0;
      rsp_status_in = mac_done ? c2d_pkg::STATUS_OK : c2d_pkg::STATUS_RANGE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_sum_ff    <= rsp_sum_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_sum    = rsp_sum_ff;
   assign rsp_status = rsp_status_ff;

endmodule

### hdl/c2d_checker.sv
// ----------------------------------------------------------------------------
// c2d_checker
// Port-level checks of the convolution block's beat and response timing.
// ----------------------------------------------------------------------------
module c2d_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic [c2d_pkg::KIND_W-1:0]  req_kind,
   input logic [c2d_pkg::FILT_W-1:0]  req_filter_index,
   input logic [c2d_pkg::POS_W-1:0]   req_row,
   input logic [c2d_pkg::POS_W-1:0]   req_col,
   input logic                        rsp_strobe,
   input logic signed [c2d_pkg::SUM_W-1:0] rsp_sum,
   input logic                        rsp_status
);

   logic take, take_load, take_good, take_bad;

   assign take      = start && !busy;
   assign take_load = take && (req_kind != c2d_pkg::KIND_COMPUTE);
   assign take_good = take && (req_kind == c2d_pkg::KIND_COMPUTE)
                      && (int'(req_filter_index) < c2d_pkg::FILTERS)
                      && (int'(req_row) < c2d_pkg::OUT_SIZE)
                      && (int'(req_col) < c2d_pkg::OUT_SIZE);
   assign take_bad  = take && (req_kind == c2d_pkg::KIND_COMPUTE) && !take_good;

   // a load beat never produces a response
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      take_load |=> !rsp_strobe)
      else $error("response after a load beat");

   // an out-of-range query is answered with error status and zero sum
   a_bad_query: assert property (@(posedge clock) disable iff (reset)
      take_bad |=> (rsp_strobe && rsp_status && (rsp_sum == '0)))
      else $error("out-of-range query not answered with error");

   // a valid query holds the block busy
   a_good_busy: assert property (@(posedge clock) disable iff (reset)
      take_good |=> busy)
      else $error("valid query did not raise busy");

   // a good result arrives exactly when busy drops, and busy drops only with it
   a_ok_on_fall: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_status) |-> $fell(busy))
      else $error("ok response outside the end of a query");

   a_fall_ok: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> (rsp_strobe && !rsp_status))
      else $error("busy dropped without a result");

endmodule

bind conv2d_5x5_multi_filter c2d_checker u_c2d_checker (.*);
